@@ rtl/kv_request_packet_parser_top_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the key/value request packet parser
// ---------------------------------------------------------------------------
`ifndef KV_REQUEST_PACKET_PARSER_TOP_ASSERT_SVH
`define KV_REQUEST_PACKET_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define KVRPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("kvrpp assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define KVRPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("kvrpp assertion failed");

`endif

@@ rtl/kvrpp_pkg.sv @@
// ---------------------------------------------------------------------------
// kvrpp_pkg
// Codes and helpers shared by the request packet parser and its checker.
// ---------------------------------------------------------------------------
package kvrpp_pkg;

	// Parse phases
	localparam logic [2:0] PH_TYPE     = 3'd0;
	localparam logic [2:0] PH_KEYLEN   = 3'd1;
	localparam logic [2:0] PH_KEY      = 3'd2;
	localparam logic [2:0] PH_VLEN     = 3'd3;
	localparam logic [2:0] PH_VALUE    = 3'd4;
	localparam logic [2:0] PH_COMPLETE = 3'd5;

	// Byte tags on the result
	localparam logic [1:0] BK_HEADER = 2'd0;
	localparam logic [1:0] BK_KEY    = 2'd1;
	localparam logic [1:0] BK_VALUE  = 2'd2;
	localparam logic [1:0] BK_EXCESS = 2'd3;

	// Request kinds; KIND_NONE marks an unknown type word
	localparam logic [2:0] KIND_PUT    = 3'd0;
	localparam logic [2:0] KIND_GET    = 3'd1;
	localparam logic [2:0] KIND_GETC   = 3'd2;
	localparam logic [2:0] KIND_DELETE = 3'd3;
	localparam logic [2:0] KIND_NONE   = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_PUT    = 2'd0;
	localparam logic [1:0] CFG_GET    = 2'd1;
	localparam logic [1:0] CFG_GETC   = 2'd2;
	localparam logic [1:0] CFG_DELETE = 2'd3;

	// Header field sizes in bytes
	localparam logic [31:0] TYPE_BYTES = 32'd4;
	localparam logic [31:0] VLEN_BYTES = 32'd4;

	// Classify a type word; earlier codes win where codes overlap
	function automatic logic [2:0] kind_of(
		input logic [31:0] tw,
		input logic [31:0] put_c,
		input logic [31:0] get_c,
		input logic [31:0] getc_c,
		input logic [31:0] del_c
	);
		logic [2:0] k;
		k = KIND_NONE;
		if (tw == put_c) k = KIND_PUT;
		else if (tw == get_c) k = KIND_GET;
		else if (tw == getc_c) k = KIND_GETC;
		else if (tw == del_c) k = KIND_DELETE;
		return k;
	endfunction

endpackage

@@ rtl/kv_request_packet_parser_top.sv @@
// ---------------------------------------------------------------------------
// kv_request_packet_parser_top
// Parses key/value request packets one byte per request and tags each byte;
// the last byte's result carries verdict, kind, lengths and identifier.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  request  | req_valid / req_ready  | data_byte, last_byte, request_id
//  result   | rsp_valid / rsp_ready  | byte_kind, payload_byte, packet_done,
//           |                        | packet_ok, request_kind, key_length,
//           |                        | value_length, id_out
//  config   | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle; its result is loaded into the result register at
// acceptance. The parse state and the result register update in the
// same edge, so the limit is the single compare/update path per byte.
// A stalled result holds; a new request is taken in the cycle the held
// result leaves. Reset clears the parse state and loads the default codes.
// ---------------------------------------------------------------------------
module kv_request_packet_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [63:0] request_id,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  byte_kind,
	output logic [7:0]  payload_byte,
	output logic        packet_done,
	output logic        packet_ok,
	output logic [1:0]  request_kind,
	output logic [7:0]  key_length,
	output logic [31:0] value_length,
	output logic [63:0] id_out,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import kvrpp_pkg::*;

	// configuration registers
	logic [31:0] put_code_q, get_code_q, getc_code_q, delete_code_q;

	// parse state
	logic [2:0]  phase_q;
	logic [31:0] field_cnt_q;
	logic [31:0] type_word_q;
	logic [7:0]  key_len_q;
	logic [31:0] value_len_q;
	logic        error_q;
	logic [63:0] held_id_q;

	// next parse state
	logic [2:0]  phase_n;
	logic [31:0] field_cnt_n;
	logic [31:0] type_word_n;
	logic [7:0]  key_len_n;
	logic [31:0] value_len_n;
	logic        error_n;
	logic [63:0] held_id_n;

	// result register
	logic        rsp_valid_q;
	logic [1:0]  byte_kind_q;
	logic [7:0]  payload_byte_q;
	logic        packet_done_q;
	logic        packet_ok_q;
	logic [1:0]  request_kind_q;
	logic [7:0]  key_length_q;
	logic [31:0] value_length_q;
	logic [63:0] id_out_q;

	logic        accept;
	logic [31:0] cnt_inc;
	logic [2:0]  kind;
	logic [1:0]  bkind;
	logic        ok;

	// take a request whenever the result slot is free or draining
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign cnt_inc   = field_cnt_q + 32'd1;
	assign kind      = kind_of(type_word_n, put_code_q, get_code_q, getc_code_q,
		delete_code_q);

	// parse one byte
	always_comb begin
		phase_n     = phase_q;
		field_cnt_n = field_cnt_q;
		type_word_n = type_word_q;
		key_len_n   = key_len_q;
		value_len_n = value_len_q;
		error_n     = error_q;
		held_id_n   = held_id_q;
		bkind       = BK_EXCESS;
		if (!error_q && phase_q == PH_TYPE && field_cnt_q == 32'd0) begin
			held_id_n = request_id;
		end
		if (!error_q) begin
			unique case (phase_q)
				PH_TYPE: begin
					bkind       = BK_HEADER;
					type_word_n = {type_word_q[23:0], data_byte};
					field_cnt_n = cnt_inc;
					if (cnt_inc >= TYPE_BYTES) begin
						phase_n     = PH_KEYLEN;
						field_cnt_n = 32'd0;
					end
				end
				PH_KEYLEN: begin
					bkind       = BK_HEADER;
					key_len_n   = data_byte;
					field_cnt_n = 32'd0;
					if (data_byte == 8'd0) begin
						// empty key: check the type right away
						if (kind == KIND_PUT) phase_n = PH_VLEN;
						else if (kind == KIND_NONE) error_n = 1'b1;
						else phase_n = PH_COMPLETE;
					end else begin
						phase_n = PH_KEY;
					end
				end
				PH_KEY: begin
					bkind = BK_KEY;
					if (data_byte == 8'd0) begin
						error_n = 1'b1;
					end else begin
						field_cnt_n = cnt_inc;
						if (cnt_inc >= {24'd0, key_len_q}) begin
							field_cnt_n = 32'd0;
							if (kind == KIND_PUT) phase_n = PH_VLEN;
							else if (kind == KIND_NONE) error_n = 1'b1;
							else phase_n = PH_COMPLETE;
						end
					end
				end
				PH_VLEN: begin
					bkind       = BK_HEADER;
					value_len_n = {value_len_q[23:0], data_byte};
					field_cnt_n = cnt_inc;
					if (cnt_inc >= VLEN_BYTES) begin
						field_cnt_n = 32'd0;
						phase_n     = (value_len_n == 32'd0) ? PH_COMPLETE : PH_VALUE;
					end
				end
				PH_VALUE: begin
					bkind       = BK_VALUE;
					field_cnt_n = cnt_inc;
					if (cnt_inc >= value_len_q) phase_n = PH_COMPLETE;
				end
				default: begin
					// byte past the end of the parsed packet
					bkind   = BK_EXCESS;
					error_n = 1'b1;
				end
			endcase
		end
		ok = last_byte && !error_n && phase_n == PH_COMPLETE && kind != KIND_NONE;
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_code_q    <= 32'd1;
			get_code_q    <= 32'd2;
			getc_code_q   <= 32'd3;
			delete_code_q <= 32'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PUT:    put_code_q    <= cfg_data;
				CFG_GET:    get_code_q    <= cfg_data;
				CFG_GETC:   getc_code_q   <= cfg_data;
				CFG_DELETE: delete_code_q <= cfg_data;
				default:    put_code_q    <= put_code_q;
			endcase
		end
	end

	// advance parse state; clear it at the end of each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			field_cnt_q <= 32'd0;
			type_word_q <= 32'd0;
			key_len_q   <= 8'd0;
			value_len_q <= 32'd0;
			error_q     <= 1'b0;
			held_id_q   <= 64'd0;
		end else if (accept) begin
			held_id_q <= held_id_n;
			if (last_byte) begin
				phase_q     <= PH_TYPE;
				field_cnt_q <= 32'd0;
				type_word_q <= 32'd0;
				key_len_q   <= 8'd0;
				value_len_q <= 32'd0;
				error_q     <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				field_cnt_q <= field_cnt_n;
				type_word_q <= type_word_n;
				key_len_q   <= key_len_n;
				value_len_q <= value_len_n;
				error_q     <= error_n;
			end
		end
	end

	// hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= req_valid;
		end
	end

	// load result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_kind_q    <= bkind;
			payload_byte_q <= data_byte;
			packet_done_q  <= last_byte;
			packet_ok_q    <= ok;
			request_kind_q <= ok ? kind[1:0] : 2'd0;
			key_length_q   <= ok ? key_len_n : 8'd0;
			value_length_q <= (ok && kind == KIND_PUT) ? value_len_n : 32'd0;
			id_out_q       <= held_id_n;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign byte_kind    = byte_kind_q;
	assign payload_byte = payload_byte_q;
	assign packet_done  = packet_done_q;
	assign packet_ok    = packet_ok_q;
	assign request_kind = request_kind_q;
	assign key_length   = key_length_q;
	assign value_length = value_length_q;
	assign id_out       = id_out_q;

endmodule

@@ rtl/kvrpp_checker.sv @@
// ---------------------------------------------------------------------------
// kvrpp_checker
// Port-level checks on the request packet parser, bound to its top level.
// ---------------------------------------------------------------------------
`include "kv_request_packet_parser_top_assert.svh"

module kvrpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  byte_kind,
	input logic [7:0]  payload_byte,
	input logic        packet_done,
	input logic        packet_ok,
	input logic [1:0]  request_kind,
	input logic [7:0]  key_length,
	input logic [31:0] value_length,
	input logic [63:0] id_out
);
	import kvrpp_pkg::*;

	logic         rsp_stall;
	logic [117:0] rsp_word;
	logic         rsp_ok;
	logic         rsp_rej;
	logic         summary_zero;
	logic         ok_not_put;

	// terms shared by the checks below
	assign rsp_stall    = rsp_valid && !rsp_ready;
	assign rsp_word     = {byte_kind, payload_byte, packet_done, packet_ok, request_kind,
		key_length, value_length, id_out};
	assign rsp_ok       = rsp_valid && packet_ok;
	assign rsp_rej      = rsp_valid && !packet_ok;
	assign summary_zero = request_kind == 2'd0 && key_length == 8'd0 && value_length == 32'd0;
	assign ok_not_put   = rsp_ok && request_kind != KIND_PUT[1:0];

	// a stalled result holds its payload
	`KVRPP_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_word))

	// an empty result slot always takes a request
	`KVRPP_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !rsp_valid, req_ready)

	// a good verdict only on a last byte that was parsed
	`KVRPP_ASSERT_IMP(a_ok_on_done, clk, arst_n, rsp_ok, packet_done && byte_kind != BK_EXCESS)

	// summary fields stay zero unless the packet is accepted
	`KVRPP_ASSERT_IMP(a_zero_when_rejected, clk, arst_n, rsp_rej, summary_zero)

	// only a put reports a value length
	`KVRPP_ASSERT_IMP(a_vlen_put_only, clk, arst_n, ok_not_put, value_length == 32'd0)

endmodule

bind kv_request_packet_parser_top kvrpp_checker u_kvrpp_checker (.*);

@@ dv/tb_kv_request_packet_parser_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for kv_request_packet_parser_top
// Sends key/value request packets one byte per request. Most are well formed
// packets of every request kind; some are cut short, carry extra bytes, have
// a zero key byte or an unknown type word, and a few are random noise. Both
// handshakes idle at random, and the type codes change between phases,
// including overlapping codes and all-zero and all-one codes. A scoreboard
// predicts the tag and verdict of every byte and checks them in order.
// ---------------------------------------------------------------------------
module tb_kv_request_packet_parser_top;
	import kvrpp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// One tagged byte as the parser reports it
	typedef struct {
		logic [1:0]  byte_kind;
		logic [7:0]  payload_byte;
		logic        packet_done;
		logic        packet_ok;
		logic [1:0]  request_kind;
		logic [7:0]  key_length;
		logic [31:0] value_length;
		logic [63:0] id_out;
	} byte_tag_t;

	// Tracks the parse of the request stream and the tags it should produce
	class tag_scoreboard;
		logic [31:0] codes [4];
		logic [2:0]  stage;
		logic [31:0] count;
		logic [31:0] word;
		logic [7:0]  key_len;
		logic [31:0] val_len;
		bit          broken;
		logic [63:0] id_held;
		byte_tag_t   expected_tags [$];
		int          errors;

		function new();
			codes[CFG_PUT]    = 32'd1;
			codes[CFG_GET]    = 32'd2;
			codes[CFG_GETC]   = 32'd3;
			codes[CFG_DELETE] = 32'd4;
			id_held = '0;
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			stage = PH_TYPE;
			count = '0;
			word = '0;
			key_len = '0;
			val_len = '0;
			broken = 0;
		endfunction

		function void set_code(logic [1:0] idx, logic [31:0] value);
			codes[idx] = value;
		endfunction

		// Earlier codes win where two codes are equal
		function logic [2:0] classify(logic [31:0] w);
			if (w == codes[CFG_PUT]) return KIND_PUT;
			if (w == codes[CFG_GET]) return KIND_GET;
			if (w == codes[CFG_GETC]) return KIND_GETC;
			if (w == codes[CFG_DELETE]) return KIND_DELETE;
			return KIND_NONE;
		endfunction

		function void finish_key();
			logic [2:0] k;
			k = classify(word);
			count = '0;
			if (k == KIND_PUT) stage = PH_VLEN;
			else if (k == KIND_NONE) broken = 1;
			else stage = PH_COMPLETE;
		endfunction

		function int pending();
			return expected_tags.size();
		endfunction

		// Advance the parse by one accepted request and hold its expected tag
		function void note_request(logic [7:0] d, logic last, logic [63:0] id);
			byte_tag_t t;
			logic [2:0] k;
			t.byte_kind = BK_EXCESS;
			t.payload_byte = d;
			t.packet_done = last;
			t.packet_ok = 1'b0;
			t.request_kind = '0;
			t.key_length = '0;
			t.value_length = '0;
			if (!broken && stage == PH_TYPE && count == 0) id_held = id;
			if (!broken) begin
				case (stage)
					PH_TYPE: begin
						t.byte_kind = BK_HEADER;
						word = {word[23:0], d};
						count++;
						if (count >= TYPE_BYTES) begin
							stage = PH_KEYLEN;
							count = '0;
						end
					end
					PH_KEYLEN: begin
						t.byte_kind = BK_HEADER;
						key_len = d;
						count = '0;
						if (d == 8'd0) finish_key();
						else stage = PH_KEY;
					end
					PH_KEY: begin
						t.byte_kind = BK_KEY;
						if (d == 8'd0) begin
							broken = 1;
						end else begin
							count++;
							if (count >= {24'd0, key_len}) finish_key();
						end
					end
					PH_VLEN: begin
						t.byte_kind = BK_HEADER;
						val_len = {val_len[23:0], d};
						count++;
						if (count >= VLEN_BYTES) begin
							count = '0;
							stage = (val_len == 0) ? PH_COMPLETE : PH_VALUE;
						end
					end
					PH_VALUE: begin
						t.byte_kind = BK_VALUE;
						count++;
						if (count >= val_len) stage = PH_COMPLETE;
					end
					default: begin
						t.byte_kind = BK_EXCESS;
						broken = 1;
					end
				endcase
			end
			// Verdict on the last byte, then drop all parse state
			if (last) begin
				if (!broken && stage == PH_COMPLETE) begin
					k = classify(word);
					if (k != KIND_NONE) begin
						t.packet_ok = 1'b1;
						t.request_kind = k[1:0];
						t.key_length = key_len;
						t.value_length = (k == KIND_PUT) ? val_len : 32'd0;
					end
				end
				clear_parse();
			end
			t.id_out = id_held;
			expected_tags.push_back(t);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare a result with the oldest expected tag
		function void check_tag(byte_tag_t got);
			byte_tag_t want;
			if (expected_tags.size() == 0) begin
				$error("payload_byte 0x%0h: result with no request pending", got.payload_byte);
				errors++;
				return;
			end
			want = expected_tags.pop_front();
			compare_field("byte_kind", want.byte_kind, got.byte_kind);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("packet_done", want.packet_done, got.packet_done);
			compare_field("packet_ok", want.packet_ok, got.packet_ok);
			compare_field("request_kind", want.request_kind, got.request_kind);
			compare_field("key_length", want.key_length, got.key_length);
			compare_field("value_length", want.value_length, got.value_length);
			compare_field("id_out", want.id_out, got.id_out);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic [63:0] request_id = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  byte_kind;
	logic [7:0]  payload_byte;
	logic        packet_done;
	logic        packet_ok;
	logic [1:0]  request_kind;
	logic [7:0]  key_length;
	logic [31:0] value_length;
	logic [63:0] id_out;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_PUT;
	logic [31:0] cfg_data = '0;

	tag_scoreboard board;
	logic [7:0]    pkt [$];
	bit            steady = 0;
	int            sent = 0;
	int            cycle_count;

	kv_request_packet_parser_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.request_id   (request_id),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.byte_kind    (byte_kind),
		.payload_byte (payload_byte),
		.packet_done  (packet_done),
		.packet_ok    (packet_ok),
		.request_kind (request_kind),
		.key_length   (key_length),
		.value_length (value_length),
		.id_out       (id_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 23);
	endfunction

	// Stall the result side at random
	always @(negedge clk) begin
		rsp_ready = !take_break();
	end

	// Check every result as it leaves
	always @(posedge clk) begin
		byte_tag_t got;
		if (arst_n && board != null && rsp_valid && rsp_ready) begin
			got.byte_kind = byte_kind;
			got.payload_byte = payload_byte;
			got.packet_done = packet_done;
			got.packet_ok = packet_ok;
			got.request_kind = request_kind;
			got.key_length = key_length;
			got.value_length = value_length;
			got.id_out = id_out;
			board.check_tag(got);
		end
	end

	// End the run if it hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Send one byte; hold valid and payload until accepted. Starts and ends at a falling edge.
	task automatic send_byte(logic [7:0] d, logic last, logic [63:0] id);
		while (take_break()) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		data_byte = d;
		last_byte = last;
		request_id = id;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		board.note_request(d, last, id);
		sent++;
		@(negedge clk);
		// drop valid; a following byte raises it again in this same step unless it idles first
		req_valid = 1'b0;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1, {$urandom, $urandom});
	endtask

	// Build a packet: type word, key length, nonzero key, and for a put the value part
	function automatic void make_packet(logic [31:0] w, int klen, logic [31:0] vlen, int nvalue);
		pkt.delete();
		for (int i = 3; i >= 0; i--) pkt.push_back(w[8*i +: 8]);
		pkt.push_back(klen[7:0]);
		repeat (klen) pkt.push_back(8'($urandom_range(1, 255)));
		if (board.classify(w) == KIND_PUT) begin
			for (int i = 3; i >= 0; i--) pkt.push_back(vlen[8*i +: 8]);
			repeat (nvalue) pkt.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic random_packet();
		int          r;
		int          klen;
		int          nvalue;
		int          n;
		logic [31:0] w;
		logic [31:0] vlen;
		r = $urandom_range(99);
		if (r < 7) begin
			// noise
			pkt.delete();
			n = $urandom_range(1, 10);
			repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(99) < 6) begin
				w = $urandom;
				while (board.classify(w) != KIND_NONE) w = $urandom;
			end else begin
				w = board.codes[$urandom_range(3)];
			end
			klen = ($urandom_range(99) < 2) ? $urandom_range(7, 255) : $urandom_range(0, 6);
			vlen = ($urandom_range(99) < 4) ? $urandom_range(7, 300) : $urandom_range(0, 6);
			nvalue = vlen;
			if ($urandom_range(99) < 3) begin
				vlen = $urandom;
				nvalue = $urandom_range(0, 3);
			end
			make_packet(w, klen, vlen, nvalue);
			// damage some packets: cut short, extra bytes, zero key byte
			r = $urandom_range(99);
			if (r < 8 && pkt.size() > 1) begin
				n = $urandom_range(1, pkt.size() - 1);
				while (pkt.size() > n) void'(pkt.pop_back());
			end else if (r < 15) begin
				n = $urandom_range(1, 3);
				repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
			end else if (r < 22 && klen > 0) begin
				pkt[5 + $urandom_range(0, klen - 1)] = 8'h00;
			end
		end
		send_packet();
	endtask

	// Wait until every expected tag has arrived, then let the block settle
	task automatic wait_idle();
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all four type codes, one per cycle
	task automatic set_codes(logic [31:0] p, logic [31:0] g, logic [31:0] gc, logic [31:0] dl);
		logic [31:0] vals [4];
		vals[CFG_PUT] = p;
		vals[CFG_GET] = g;
		vals[CFG_GETC] = gc;
		vals[CFG_DELETE] = dl;
		for (int i = 0; i < 4; i++) begin
			cfg_we = 1'b1;
			cfg_index = 2'(i);
			cfg_data = vals[i];
			@(posedge clk);
			board.set_code(2'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	initial begin
		int          start;
		logic [31:0] w;
		board = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed packets with reset codes
		make_packet(board.codes[CFG_GET], 1, 0, 0);
		send_packet();
		// zero key length, then one excess byte
		make_packet(board.codes[CFG_DELETE], 0, 0, 0);
		pkt.push_back(8'hFF);
		send_packet();
		// put with empty key and empty value
		make_packet(board.codes[CFG_PUT], 0, 0, 0);
		send_packet();
		// short packet: a lone last byte
		pkt = '{8'h00};
		send_packet();
		// zero key byte, followed by a byte after the error
		make_packet(board.codes[CFG_GETC], 3, 0, 0);
		pkt[6] = 8'h00;
		send_packet();

		// Random packets under several code settings
		for (int ph = 0; ph < 7; ph++) begin
			wait_idle();
			steady = (ph == 3);
			case (ph)
				1: set_codes($urandom, $urandom, $urandom, $urandom);
				2: set_codes(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				3: begin
					w = $urandom;
					set_codes(w, w, w, w);
				end
				4: begin
					w = $urandom;
					set_codes($urandom, w, w, w);
				end
				5: begin
					w = $urandom;
					set_codes(32'hFFFF_FFFF, 32'h0000_0000, w, w);
				end
				6: set_codes(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE);
				default: ;
			endcase
			start = sent;
			while (sent - start < 170) random_packet();
		end

		req_valid = 1'b0;
		steady = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
